>>> design/drive_bus_write_event_decoder_macros.svh
// Assertion macros used by the checker of the drive bus write event decoder.
`ifndef DRIVE_BUS_WRITE_EVENT_DECODER_MACROS_SVH
`define DRIVE_BUS_WRITE_EVENT_DECODER_MACROS_SVH

// Checks that a property holds in the same cycle as its trigger.
`define DBWE_ASSERT_NOW(label, clk, rst_n, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
		else $error("event decoder check failed");

// Checks that a property holds in the cycle after its trigger.
`define DBWE_ASSERT_NEXT(label, clk, rst_n, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
		else $error("event decoder check failed");

`endif

>>> design/dbwe_pkg.sv
// Types and constants shared by the drive bus write event decoder modules.
`timescale 1ns / 1ps

package dbwe_pkg;

	// Event kinds.
	localparam logic [2:0] KIND_MOTOR       = 3'd0;
	localparam logic [2:0] KIND_PHASE_STEP  = 3'd1;
	localparam logic [2:0] KIND_DENSITY     = 3'd2;
	localparam logic [2:0] KIND_TRACK_WRITE = 3'd3;
	localparam logic [2:0] KIND_PROTECT     = 3'd4;
	localparam logic [2:0] KIND_TRACK_STATE = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_PROTECT = 2'd0;
	localparam logic [1:0] REG_STATUS  = 2'd1;
	localparam logic [1:0] REG_TRACK   = 2'd2;

	localparam int ADDR_W     = 13;
	localparam int MAX_EVENTS = 4;
	localparam int EV_IDX_W   = $clog2(MAX_EVENTS);
	localparam int EV_CNT_W   = $clog2(MAX_EVENTS + 1);

	localparam logic [ADDR_W-1:0] PROTECT_ADDR_RESET = 13'h001E;
	localparam logic [ADDR_W-1:0] STATUS_ADDR_RESET  = 13'h0020;
	localparam logic [ADDR_W-1:0] TRACK_ADDR_RESET   = 13'h0022;

	localparam logic [7:0] HEAD_MAX      = 8'd254;
	localparam logic [7:0] HEAD_MIN      = 8'd2;
	localparam logic [7:0] TRACK_MAX     = 8'd127;
	localparam logic [1:0] DENSITY_RESET = 2'd2;
	localparam logic [1:0] DELTA_UP      = 2'd1;
	localparam logic [1:0] DELTA_DOWN    = 2'd3;

	// One result item, without the end-of-run flag.
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
		logic [1:0] old_phase;
		logic [1:0] new_phase;
		logic [1:0] phase_delta;
		logic       motor_at_step;
		logic [7:0] track_byte;
		logic       track_byte_known;
		logic [7:0] half_track_pos;
		logic       pos_known;
		logic       stepping_now;
	} evt_t;

	// All results caused by one snapshot, in order.
	typedef struct packed {
		evt_t [MAX_EVENTS-1:0] ev;
		logic [EV_CNT_W-1:0]   count;
	} bundle_t;

endpackage

>>> design/dbwe_front.sv
// Front end: unscrambles a snapshot, tracks drive state and builds its result bundle.
`timescale 1ns / 1ps

module dbwe_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [dbwe_pkg::ADDR_W-1:0] cfg_data,
	input  logic                       snap_valid,
	input  logic [25:0]                bus_snapshot,
	input  logic                       queue_full,
	output logic                       snap_stall,
	output logic                       push,
	output dbwe_pkg::bundle_t          bundle
);
	import dbwe_pkg::*;

	// Watched address registers.
	logic [ADDR_W-1:0] addr_protect_q, addr_status_q, addr_track_q;

	// Drive state.
	logic       phase_seen_q, motor_seen_q, prev_motor_q, protect_seen_q, prev_protect_q;
	logic       density_seen_q, track_seen_q, anchored_q, step_active_q;
	logic [1:0] prev_phase_q, prev_density_q;
	logic [7:0] prev_track_q, head_q;

	// Next drive state for the snapshot on the port.
	logic       n_phase_seen, n_motor_seen, n_prev_motor, n_protect_seen, n_prev_protect;
	logic       n_density_seen, n_track_seen, n_anchored, n_step_active;
	logic [1:0] n_prev_phase, n_prev_density;
	logic [7:0] n_prev_track, n_head;

	logic [ADDR_W-1:0]   addr;
	logic [7:0]          data;
	logic                selected;
	logic                motor, wp;
	logic [1:0]          phase, density, delta;
	logic [8:0]          twice;
	logic [EV_CNT_W-1:0] k;
	bundle_t             bundle_d;
	logic                accept;

	// Snapshot of the head and track bookkeeping as a result item.
	function automatic evt_t pos_report(input logic [7:0] trk, input logic trk_seen,
			input logic [7:0] head, input logic anch, input logic step);
		evt_t e;
		e                  = '0;
		e.kind             = KIND_TRACK_STATE;
		e.track_byte       = trk;
		e.track_byte_known = trk_seen;
		e.half_track_pos   = head;
		e.pos_known        = anch;
		e.stepping_now     = step;
		return e;
	endfunction

	// A plain result item carrying a kind and a value.
	function automatic evt_t simple_evt(input logic [2:0] kind, input logic [7:0] value);
		evt_t e;
		e       = '0;
		e.kind  = kind;
		e.value = value;
		return e;
	endfunction

	// Pin unscrambling.
	always_comb begin
		for (int i = 0; i <= 10; i++) begin
			addr[i] = bus_snapshot[23-i];
		end
		addr[11] = bus_snapshot[11];
		addr[12] = bus_snapshot[12];
		data     = {bus_snapshot[4], bus_snapshot[3], bus_snapshot[2], bus_snapshot[1],
			bus_snapshot[0], bus_snapshot[5], bus_snapshot[6], bus_snapshot[7]};
		selected = bus_snapshot[24] & ~bus_snapshot[25];
	end

	// Classification, state update and result assembly, in handling order.
	always_comb begin
		n_phase_seen   = phase_seen_q;
		n_prev_phase   = prev_phase_q;
		n_motor_seen   = motor_seen_q;
		n_prev_motor   = prev_motor_q;
		n_protect_seen = protect_seen_q;
		n_prev_protect = prev_protect_q;
		n_density_seen = density_seen_q;
		n_prev_density = prev_density_q;
		n_track_seen   = track_seen_q;
		n_prev_track   = prev_track_q;
		n_anchored     = anchored_q;
		n_head         = head_q;
		n_step_active  = step_active_q;
		motor          = data[2];
		phase          = data[1:0];
		density        = data[6:5];
		wp             = data[4];
		delta          = data[1:0] - prev_phase_q;
		twice          = '0;
		k              = '0;
		bundle_d       = '0;

		// Port-B write to the interface chip.
		if (selected && addr[3:0] == 4'd0) begin
			if (!n_motor_seen || motor != n_prev_motor) begin
				n_motor_seen = 1'b1;
				n_prev_motor = motor;
				bundle_d.ev[k[EV_IDX_W-1:0]] = simple_evt(KIND_MOTOR, {7'd0, motor});
				k = k + 1'b1;
			end
			if (!n_phase_seen) begin
				n_phase_seen = 1'b1;
				n_prev_phase = phase;
			end else if (phase != n_prev_phase) begin
				bundle_d.ev[k[EV_IDX_W-1:0]]               = simple_evt(KIND_PHASE_STEP, 8'd0);
				bundle_d.ev[k[EV_IDX_W-1:0]].old_phase     = n_prev_phase;
				bundle_d.ev[k[EV_IDX_W-1:0]].new_phase     = phase;
				bundle_d.ev[k[EV_IDX_W-1:0]].phase_delta   = delta;
				bundle_d.ev[k[EV_IDX_W-1:0]].motor_at_step = motor;
				k            = k + 1'b1;
				n_prev_phase = phase;
				if (n_anchored) begin
					if (delta == DELTA_UP) begin
						if (n_head < HEAD_MAX) begin
							n_head = n_head + 8'd1;
						end
					end else if (delta == DELTA_DOWN) begin
						n_head = (n_head > HEAD_MIN) ? n_head - 8'd1 : HEAD_MIN;
					end
					bundle_d.ev[k[EV_IDX_W-1:0]] = pos_report(n_prev_track, n_track_seen,
						n_head, n_anchored, n_step_active);
					k = k + 1'b1;
				end
			end
			if (!n_density_seen || density != n_prev_density) begin
				n_density_seen = 1'b1;
				n_prev_density = density;
				bundle_d.ev[k[EV_IDX_W-1:0]] = simple_evt(KIND_DENSITY, {6'd0, density});
				k = k + 1'b1;
			end
		end

		// Status variable: a falling stepping flag anchors at the known track.
		if (!selected && addr == addr_status_q) begin
			if (n_step_active && !data[6] && n_track_seen && n_prev_track >= 8'd1 &&
					n_prev_track <= TRACK_MAX) begin
				twice      = {n_prev_track, 1'b0};
				n_head     = (twice > {1'b0, HEAD_MAX}) ? HEAD_MAX : twice[7:0];
				n_anchored = 1'b1;
			end
			n_step_active = data[6];
			bundle_d.ev[k[EV_IDX_W-1:0]] = pos_report(n_prev_track, n_track_seen,
				n_head, n_anchored, n_step_active);
			k = k + 1'b1;
		end

		// Track variable: a new target track, possibly anchoring the head.
		if (!selected && addr == addr_track_q) begin
			n_prev_track = data;
			n_track_seen = 1'b1;
			bundle_d.ev[k[EV_IDX_W-1:0]] = simple_evt(KIND_TRACK_WRITE, data);
			k = k + 1'b1;
			if (data == 8'd1) begin
				n_head     = HEAD_MIN;
				n_anchored = 1'b1;
			end else if (!n_anchored && !n_step_active && data >= 8'd1 && data <= TRACK_MAX) begin
				twice      = {data, 1'b0};
				n_head     = (twice > {1'b0, HEAD_MAX}) ? HEAD_MAX : twice[7:0];
				n_anchored = 1'b1;
			end
			bundle_d.ev[k[EV_IDX_W-1:0]] = pos_report(n_prev_track, n_track_seen,
				n_head, n_anchored, n_step_active);
			k = k + 1'b1;
		end

		// Protect variable: write-protect change.
		if (!selected && addr == addr_protect_q) begin
			if (!n_protect_seen || wp != n_prev_protect) begin
				n_protect_seen = 1'b1;
				n_prev_protect = wp;
				bundle_d.ev[k[EV_IDX_W-1:0]] = simple_evt(KIND_PROTECT, {7'd0, wp});
				k = k + 1'b1;
			end
		end

		bundle_d.count = k;
	end

	assign snap_stall = queue_full;
	assign accept     = snap_valid && !queue_full;
	assign push       = accept && (bundle_d.count != '0);
	assign bundle     = bundle_d;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_protect_q <= PROTECT_ADDR_RESET;
			addr_status_q  <= STATUS_ADDR_RESET;
			addr_track_q   <= TRACK_ADDR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROTECT: addr_protect_q <= cfg_data;
				REG_STATUS:  addr_status_q  <= cfg_data;
				REG_TRACK:   addr_track_q   <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Drive state advances on each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_seen_q   <= 1'b0;
			prev_phase_q   <= 2'd0;
			motor_seen_q   <= 1'b0;
			prev_motor_q   <= 1'b0;
			protect_seen_q <= 1'b0;
			prev_protect_q <= 1'b0;
			density_seen_q <= 1'b0;
			prev_density_q <= DENSITY_RESET;
			track_seen_q   <= 1'b0;
			prev_track_q   <= 8'd0;
			anchored_q     <= 1'b0;
			head_q         <= 8'd0;
			step_active_q  <= 1'b0;
		end else if (accept) begin
			phase_seen_q   <= n_phase_seen;
			prev_phase_q   <= n_prev_phase;
			motor_seen_q   <= n_motor_seen;
			prev_motor_q   <= n_prev_motor;
			protect_seen_q <= n_protect_seen;
			prev_protect_q <= n_prev_protect;
			density_seen_q <= n_density_seen;
			prev_density_q <= n_prev_density;
			track_seen_q   <= n_track_seen;
			prev_track_q   <= n_prev_track;
			anchored_q     <= n_anchored;
			head_q         <= n_head;
			step_active_q  <= n_step_active;
		end
	end

endmodule

>>> design/dbwe_queue.sv
// Two-entry queue of result bundles between the front and back ends.
`timescale 1ns / 1ps

module dbwe_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dbwe_pkg::bundle_t wr_bundle,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output dbwe_pkg::bundle_t rd_bundle
);
	import dbwe_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	bundle_t          entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full      = (cnt_q == (PTR_W+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_bundle = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_bundle;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

>>> design/dbwe_back.sv
// Back end: hands out the results of each bundle one transfer at a time.
`timescale 1ns / 1ps

module dbwe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              not_empty,
	input  dbwe_pkg::bundle_t head,
	output logic              pop,
	input  logic              evt_stall,
	output logic              evt_valid,
	output dbwe_pkg::evt_t    evt,
	output logic              last_of_run
);
	import dbwe_pkg::*;

	logic [EV_IDX_W-1:0] idx_q;
	logic                evt_valid_q;
	evt_t                evt_q;
	logic                last_q;
	logic                load;
	logic                is_last;

	// The output register takes a new result when empty or being drained.
	assign load    = not_empty && (!evt_valid_q || !evt_stall);
	assign is_last = ({1'b0, idx_q} == head.count - 1'b1);
	assign pop     = load && is_last;

	// Position within the current bundle and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			evt_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			end
			if (load) begin
				evt_valid_q <= 1'b1;
			end else if (!evt_stall) begin
				evt_valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			evt_q  <= head.ev[idx_q];
			last_q <= is_last;
		end
	end

	assign evt_valid   = evt_valid_q;
	assign evt         = evt_q;
	assign last_of_run = last_q;

endmodule

>>> design/drive_bus_write_event_decoder.sv
// Top level of the drive bus write event decoder.
`timescale 1ns / 1ps

// Takes one raw bus write snapshot per transfer and reports motor, stepper phase,
// density, write-protect and track events of the disk drive, each transfer on the
// event channel carrying one result, with last_of_run set on the final result of
// a snapshot. A snapshot is classified and the drive state updated in the cycle it
// is accepted; its bundle is then written to a queue entry, and its results are
// loaded one at a time into the back end's output register, which presents them
// on the event channel. The event channel moves one result per cycle while
// evt_stall is low; snapshots with one result or none can be accepted in every
// cycle while the event channel is not stalled, and a two-bundle queue lets the
// input keep going while longer runs drain. The watched addresses must only be
// written while no results are pending.
module drive_bus_write_event_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        snap_valid,
	output logic        snap_stall,
	input  logic [25:0] bus_snapshot,
	output logic        evt_valid,
	input  logic        evt_stall,
	output logic [2:0]  event_kind,
	output logic [7:0]  event_value,
	output logic [1:0]  old_phase,
	output logic [1:0]  new_phase,
	output logic [1:0]  phase_delta,
	output logic        motor_at_step,
	output logic [7:0]  track_byte,
	output logic        track_byte_known,
	output logic [7:0]  half_track_pos,
	output logic        pos_known,
	output logic        stepping_now,
	output logic        last_of_run
);
	import dbwe_pkg::*;

	logic    push, pop, full, not_empty;
	bundle_t wr_bundle, rd_bundle;
	evt_t    evt;

	dbwe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.snap_valid   (snap_valid),
		.bus_snapshot (bus_snapshot),
		.queue_full   (full),
		.snap_stall   (snap_stall),
		.push         (push),
		.bundle       (wr_bundle)
	);

	dbwe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_bundle (wr_bundle),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.rd_bundle (rd_bundle)
	);

	dbwe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.not_empty   (not_empty),
		.head        (rd_bundle),
		.pop         (pop),
		.evt_stall   (evt_stall),
		.evt_valid   (evt_valid),
		.evt         (evt),
		.last_of_run (last_of_run)
	);

	// Result fields onto their own ports.
	assign event_kind       = evt.kind;
	assign event_value      = evt.value;
	assign old_phase        = evt.old_phase;
	assign new_phase        = evt.new_phase;
	assign phase_delta      = evt.phase_delta;
	assign motor_at_step    = evt.motor_at_step;
	assign track_byte       = evt.track_byte;
	assign track_byte_known = evt.track_byte_known;
	assign half_track_pos   = evt.half_track_pos;
	assign pos_known        = evt.pos_known;
	assign stepping_now     = evt.stepping_now;

endmodule

>>> design/dbwe_checker.sv
// Port checker for the drive bus write event decoder, bound to its top level.
`timescale 1ns / 1ps
`include "drive_bus_write_event_decoder_macros.svh"

module dbwe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        evt_valid,
	input logic        evt_stall,
	input logic [2:0]  event_kind,
	input logic [7:0]  event_value,
	input logic [1:0]  old_phase,
	input logic [1:0]  new_phase,
	input logic [1:0]  phase_delta,
	input logic        motor_at_step,
	input logic [7:0]  half_track_pos,
	input logic        pos_known,
	input logic        last_of_run
);
	import dbwe_pkg::*;

	// A stalled result holds until its transfer.
	`DBWE_ASSERT_NEXT(a_evt_hold, clk, arst_n, evt_valid && evt_stall, evt_valid && $stable(event_kind) && $stable(event_value) && $stable(last_of_run))

	// A phase step reports a real change and its modulo-four distance.
	`DBWE_ASSERT_NOW(a_phase_delta, clk, arst_n, evt_valid && event_kind == KIND_PHASE_STEP, old_phase != new_phase && phase_delta == 2'(new_phase - old_phase) && event_value == 8'd0)

	// Phase fields are zero on every other kind of result.
	`DBWE_ASSERT_NOW(a_phase_zero, clk, arst_n, evt_valid && event_kind != KIND_PHASE_STEP, old_phase == 2'd0 && new_phase == 2'd0 && phase_delta == 2'd0 && !motor_at_step)

	// An anchored head position stays within its saturation limits.
	`DBWE_ASSERT_NOW(a_head_range, clk, arst_n, evt_valid && event_kind == KIND_TRACK_STATE && pos_known, half_track_pos >= HEAD_MIN && half_track_pos <= HEAD_MAX)

	// Only the six defined kinds are ever reported.
	`DBWE_ASSERT_NOW(a_kind_range, clk, arst_n, evt_valid, event_kind <= KIND_TRACK_STATE)

endmodule

bind drive_bus_write_event_decoder dbwe_checker u_dbwe_checker (.*);

>>> tb/drive_bus_write_event_decoder_tb.sv
// Self-checking testbench for the drive bus write event decoder.
`timescale 1ns / 1ps

module drive_bus_write_event_decoder_tb;
	import dbwe_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 150;

	// Select pin pairs {s25, s24}; only the first one addresses the interface chip.
	localparam logic [1:0] PINS_SELECTED = 2'b01;
	localparam logic [1:0] PINS_NONE     = 2'b00;
	localparam logic [1:0] PINS_HIGH     = 2'b10;
	localparam logic [1:0] PINS_BOTH     = 2'b11;

	// One expected result with its end-of-run flag.
	typedef struct packed {
		evt_t ev;
		logic last;
	} drive_evt_t;

	// One row of directed stimulus; typed rows carry their results by hand.
	typedef struct {
		logic [25:0] snap;
		bit          typed;
		int          count;
		logic [2:0]  kind0;
		logic [7:0]  val0;
		logic [2:0]  kind1;
		logic [7:0]  val1;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_PROTECT;
	logic [12:0] cfg_data = '0;
	logic        snap_valid = 1'b0;
	logic        snap_stall;
	logic [25:0] bus_snapshot = '0;
	logic        evt_valid;
	logic        evt_stall = 1'b0;
	logic [2:0]  event_kind;
	logic [7:0]  event_value;
	logic [1:0]  old_phase;
	logic [1:0]  new_phase;
	logic [1:0]  phase_delta;
	logic        motor_at_step;
	logic [7:0]  track_byte;
	logic        track_byte_known;
	logic [7:0]  half_track_pos;
	logic        pos_known;
	logic        stepping_now;
	logic        last_of_run;

	drive_bus_write_event_decoder i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.snap_valid       (snap_valid),
		.snap_stall       (snap_stall),
		.bus_snapshot     (bus_snapshot),
		.evt_valid        (evt_valid),
		.evt_stall        (evt_stall),
		.event_kind       (event_kind),
		.event_value      (event_value),
		.old_phase        (old_phase),
		.new_phase        (new_phase),
		.phase_delta      (phase_delta),
		.motor_at_step    (motor_at_step),
		.track_byte       (track_byte),
		.track_byte_known (track_byte_known),
		.half_track_pos   (half_track_pos),
		.pos_known        (pos_known),
		.stepping_now     (stepping_now),
		.last_of_run      (last_of_run)
	);

	always #CLK_HALF clk = ~clk;

	// Watched addresses as last written to the block.
	logic [12:0] protect_addr = PROTECT_ADDR_RESET;
	logic [12:0] status_addr  = STATUS_ADDR_RESET;
	logic [12:0] track_addr   = TRACK_ADDR_RESET;

	// Drive state as the decoder should hold it.
	bit         motor_known, phase_known, density_known, protect_known, track_known;
	bit         anchored, stepping;
	logic       motor_q, protect_q;
	logic [1:0] phase_q;
	logic [1:0] density_q = DENSITY_RESET;
	logic [7:0] track_q = 8'd0;
	logic [7:0] head_pos = 8'd0;

	drive_evt_t write_events[$];
	drive_evt_t expected_events[$];
	stim_row_t  directed_rows[$];

	int mismatches = 0;
	int cycles = 0;
	int sender_gap_pct = 0;
	int receiver_stall_pct = 0;

	// State of the random firmware-like stimulus.
	logic [1:0] gen_phase = 2'd0;
	logic [1:0] gen_dir = DELTA_UP;
	logic       gen_motor = 1'b1;
	logic [1:0] gen_density = DENSITY_RESET;

	// Scrambles a logical address and data byte onto the bus pins.
	function automatic logic [25:0] pin_word(input logic [12:0] a, input logic [7:0] d,
			input logic [1:0] sel, input logic [2:0] spare);
		logic [25:0] s;
		s = '0;
		for (int i = 0; i <= 10; i++)
			s[23 - i] = a[i];
		s[25:24] = sel;
		s[12] = a[12];
		s[11] = a[11];
		s[10:8] = spare;
		s[7] = d[0];
		s[6] = d[1];
		s[5] = d[2];
		s[0] = d[3];
		s[1] = d[4];
		s[2] = d[5];
		s[3] = d[6];
		s[4] = d[7];
		return s;
	endfunction

	// A RAM write, with any select pattern that does not address the chip.
	function automatic logic [25:0] ram_write(input logic [12:0] a, input logic [7:0] d);
		logic [1:0] sel;
		case ($urandom_range(2))
			0: sel = PINS_NONE;
			1: sel = PINS_HIGH;
			default: sel = PINS_BOTH;
		endcase
		return pin_word(a, d, sel, 3'($urandom));
	endfunction

	// A port-B write; unused data bits are random.
	function automatic logic [25:0] port_b(input logic [12:0] a, input logic mot,
			input logic [1:0] ph, input logic [1:0] dens);
		logic [7:0] d;
		d = 8'($urandom);
		d[1:0] = ph;
		d[2] = mot;
		d[6:5] = dens;
		return pin_word({a[12:4], 4'h0}, d, PINS_SELECTED, 3'($urandom));
	endfunction

	function automatic stim_row_t predicted(input logic [25:0] snap);
		stim_row_t rw;
		rw = '{snap, 1'b0, 0, '0, '0, '0, '0};
		return rw;
	endfunction

	function automatic stim_row_t typed_row(input logic [25:0] snap, input int n,
			input logic [2:0] k0, input logic [7:0] v0, input logic [2:0] k1, input logic [7:0] v1);
		stim_row_t rw;
		rw = '{snap, 1'b1, n, k0, v0, k1, v1};
		return rw;
	endfunction

	function automatic void push_plain(input logic [2:0] kind, input logic [7:0] value);
		drive_evt_t r;
		r = '0;
		r.ev.kind = kind;
		r.ev.value = value;
		write_events.push_back(r);
	endfunction

	function automatic void push_track_state();
		drive_evt_t r;
		r = '0;
		r.ev.kind = KIND_TRACK_STATE;
		r.ev.track_byte = track_q;
		r.ev.track_byte_known = track_known;
		r.ev.half_track_pos = head_pos;
		r.ev.pos_known = anchored;
		r.ev.stepping_now = stepping;
		write_events.push_back(r);
	endfunction

	// Track numbers up to the top track map to twice their value in half tracks.
	function automatic void anchor_head(input logic [7:0] t);
		head_pos = ({1'b0, t} * 2 > HEAD_MAX) ? HEAD_MAX : {t[6:0], 1'b0};
		anchored = 1'b1;
	endfunction

	// Decodes one bus write, updates the drive state and collects its events.
	function automatic void decode_bus_write(input logic [25:0] s);
		logic [12:0] a;
		logic [7:0]  d;
		logic        sel, mot, wp, was;
		logic [1:0]  ph, dens, delta;
		drive_evt_t  r;
		write_events.delete();
		for (int i = 0; i <= 10; i++)
			a[i] = s[23 - i];
		a[11] = s[11];
		a[12] = s[12];
		d = {s[4], s[3], s[2], s[1], s[0], s[5], s[6], s[7]};
		sel = s[24] & ~s[25];

		// Port-B write: motor, stepper phase and density.
		if (sel && a[3:0] == 4'h0) begin
			mot = d[2];
			ph = d[1:0];
			dens = d[6:5];
			if (!motor_known || mot != motor_q) begin
				motor_known = 1'b1;
				motor_q = mot;
				push_plain(KIND_MOTOR, {7'd0, mot});
			end
			if (!phase_known) begin
				phase_known = 1'b1;
				phase_q = ph;
			end else if (ph != phase_q) begin
				delta = ph - phase_q;
				r = '0;
				r.ev.kind = KIND_PHASE_STEP;
				r.ev.old_phase = phase_q;
				r.ev.new_phase = ph;
				r.ev.phase_delta = delta;
				r.ev.motor_at_step = mot;
				write_events.push_back(r);
				phase_q = ph;
				if (anchored) begin
					if (delta == DELTA_UP) begin
						if (head_pos < HEAD_MAX)
							head_pos = head_pos + 8'd1;
					end else if (delta == DELTA_DOWN) begin
						head_pos = (head_pos > HEAD_MIN) ? head_pos - 8'd1 : HEAD_MIN;
					end
					push_track_state();
				end
			end
			if (!density_known || dens != density_q) begin
				density_known = 1'b1;
				density_q = dens;
				push_plain(KIND_DENSITY, {6'd0, dens});
			end
		end

		// Status variable: a falling step flag re-anchors on a valid track byte.
		if (!sel && a == status_addr) begin
			was = stepping;
			stepping = d[6];
			if (was && !stepping && track_known && track_q >= 8'd1 && track_q <= TRACK_MAX)
				anchor_head(track_q);
			push_track_state();
		end

		// Track variable: track one always anchors, others only when free to.
		if (!sel && a == track_addr) begin
			track_q = d;
			track_known = 1'b1;
			push_plain(KIND_TRACK_WRITE, d);
			if (d == 8'd1 || (!anchored && !stepping && d >= 8'd2 && d <= TRACK_MAX))
				anchor_head(d);
			push_track_state();
		end

		// Write-protect variable.
		if (!sel && a == protect_addr) begin
			wp = d[4];
			if (!protect_known || wp != protect_q) begin
				protect_known = 1'b1;
				protect_q = wp;
				push_plain(KIND_PROTECT, {7'd0, wp});
			end
		end

		if (write_events.size() > 0)
			write_events[write_events.size() - 1].last = 1'b1;
	endfunction

	// Random bus write, mostly firmware-like sequences with some noise.
	function automatic logic [25:0] random_write();
		logic [12:0] a;
		logic [7:0]  d;
		int          pick;
		pick = $urandom_range(99);
		d = 8'($urandom);
		if (pick < 35) begin
			// Stepper runs in one direction, turning now and then.
			if ($urandom_range(7) == 0)
				gen_dir = (gen_dir == DELTA_UP) ? DELTA_DOWN : DELTA_UP;
			case ($urandom_range(9))
				0: ;
				1: gen_phase = gen_phase + 2'd2;
				default: gen_phase = gen_phase + gen_dir;
			endcase
			if ($urandom_range(9) == 0)
				gen_motor = ~gen_motor;
			if ($urandom_range(9) == 0)
				gen_density = 2'($urandom);
			return port_b(13'($urandom), gen_motor, gen_phase, gen_density);
		end else if (pick < 50) begin
			return ram_write(status_addr, d);
		end else if (pick < 70) begin
			case ($urandom_range(9))
				0, 1:    d = 8'd1;
				2:       d = 8'd0;
				3, 4:    d = 8'($urandom_range(100, 127));
				5, 6, 7: d = 8'($urandom_range(2, 99));
				default: d = 8'($urandom_range(128, 255));
			endcase
			return ram_write(track_addr, d);
		end else if (pick < 80) begin
			return ram_write(protect_addr, d);
		end
		// Noise: raw pins, wrong chip register, broken select, near-miss addresses.
		a = 13'($urandom);
		case ($urandom_range(3))
			0: return 26'($urandom);
			1: return pin_word({a[12:4], 4'($urandom_range(1, 15))}, d, PINS_SELECTED,
					3'($urandom));
			2: return ram_write({a[12:4], 4'h0}, d);
			default: begin
				case ($urandom_range(2))
					0: a = status_addr;
					1: a = track_addr;
					default: a = protect_addr;
				endcase
				return ram_write(a ^ (13'd1 << $urandom_range(12)), d);
			end
		endcase
	endfunction

	// Presents one snapshot, waits for its transfer and records the expected events.
	task automatic send_snapshot(input stim_row_t rw);
		drive_evt_t r;
		while ($urandom_range(99) < sender_gap_pct) begin
			snap_valid <= 1'b0;
			@(posedge clk);
		end
		snap_valid <= 1'b1;
		bus_snapshot <= rw.snap;
		do
			@(posedge clk);
		while (snap_stall !== 1'b0);
		decode_bus_write(rw.snap);
		if (rw.typed) begin
			for (int j = 0; j < rw.count; j++) begin
				r = '0;
				r.ev.kind = (j == 0) ? rw.kind0 : rw.kind1;
				r.ev.value = (j == 0) ? rw.val0 : rw.val1;
				r.last = (j == rw.count - 1);
				expected_events.push_back(r);
			end
		end else begin
			foreach (write_events[j])
				expected_events.push_back(write_events[j]);
		end
	endtask

	// Stops sending and lets every pending event drain.
	task automatic drain_events();
		snap_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all three watched addresses while the block is idle.
	task automatic write_watch_addrs(input logic [12:0] prot, input logic [12:0] stat,
			input logic [12:0] trk);
		cfg_we <= 1'b1;
		cfg_index <= REG_PROTECT;
		cfg_data <= prot;
		@(posedge clk);
		cfg_index <= REG_STATUS;
		cfg_data <= stat;
		@(posedge clk);
		cfg_index <= REG_TRACK;
		cfg_data <= trk;
		@(posedge clk);
		cfg_we <= 1'b0;
		protect_addr = prot;
		status_addr = stat;
		track_addr = trk;
	endtask

	task automatic random_run(input int n);
		for (int i = 0; i < n; i++)
			send_snapshot(predicted(random_write()));
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Receiver stalls the event channel at random.
	always @(posedge clk)
		evt_stall <= ($urandom_range(99) < receiver_stall_pct);

	// Every event transfer is compared with the oldest expectation.
	always @(posedge clk) begin : check_events
		drive_evt_t want;
		if (arst_n && evt_valid === 1'b1 && evt_stall === 1'b0) begin
			if (expected_events.size() == 0) begin
				$display("%0t ns: unexpected event: expected none, actual kind %0d value %0d",
					$time, event_kind, event_value);
				mismatches++;
			end else begin
				want = expected_events.pop_front();
				check_field("event_kind", want.ev.kind, event_kind);
				check_field("event_value", want.ev.value, event_value);
				check_field("old_phase", want.ev.old_phase, old_phase);
				check_field("new_phase", want.ev.new_phase, new_phase);
				check_field("phase_delta", want.ev.phase_delta, phase_delta);
				check_field("motor_at_step", want.ev.motor_at_step, motor_at_step);
				check_field("track_byte", want.ev.track_byte, track_byte);
				check_field("track_byte_known", want.ev.track_byte_known, track_byte_known);
				check_field("half_track_pos", want.ev.half_track_pos, half_track_pos);
				check_field("pos_known", want.ev.pos_known, pos_known);
				check_field("stepping_now", want.ev.stepping_now, stepping_now);
				check_field("last_of_run", want.last, last_of_run);
			end
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** drive_bus_write_event_decoder: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_gap_pct = 36;
		receiver_stall_pct = 61;

		// Unmatched writes: unwatched RAM address, wrong chip register, both selects high.
		directed_rows.push_back(typed_row(pin_word(13'h1FFF, 8'hFF, PINS_NONE, 3'b111), 0,
			'0, '0, '0, '0));
		directed_rows.push_back(typed_row(pin_word(13'h000F, 8'hFF, PINS_SELECTED, 3'b000), 0,
			'0, '0, '0, '0));
		directed_rows.push_back(typed_row(pin_word(13'h0000, 8'h00, PINS_BOTH, 3'b101), 0,
			'0, '0, '0, '0));
		// First port-B write after reset reports motor and density, phase only recorded.
		directed_rows.push_back(typed_row(port_b(13'h0000, 1'b1, 2'd0, 2'd2), 2,
			KIND_MOTOR, 8'd1, KIND_DENSITY, 8'd2));
		directed_rows.push_back(typed_row(port_b(13'h0AA0, 1'b1, 2'd0, 2'd2), 0,
			'0, '0, '0, '0));
		directed_rows.push_back(typed_row(port_b(13'h0550, 1'b0, 2'd0, 2'd2), 1,
			KIND_MOTOR, 8'd0, '0, '0));
		directed_rows.push_back(typed_row(port_b(13'h1FF0, 1'b0, 2'd0, 2'd3), 1,
			KIND_DENSITY, 8'd3, '0, '0));
		// Phase steps while unanchored: up, by two, and a wrap with motor and density.
		directed_rows.push_back(predicted(port_b(13'h0000, 1'b0, 2'd1, 2'd3)));
		directed_rows.push_back(predicted(port_b(13'h0000, 1'b0, 2'd3, 2'd3)));
		directed_rows.push_back(predicted(port_b(13'h0000, 1'b1, 2'd0, 2'd0)));
		// Write-protect: first sighting, change, no change.
		directed_rows.push_back(typed_row(ram_write(PROTECT_ADDR_RESET, 8'h10), 1,
			KIND_PROTECT, 8'd1, '0, '0));
		directed_rows.push_back(typed_row(ram_write(PROTECT_ADDR_RESET, 8'hEF), 1,
			KIND_PROTECT, 8'd0, '0, '0));
		directed_rows.push_back(typed_row(ram_write(PROTECT_ADDR_RESET, 8'h00), 0,
			'0, '0, '0, '0));
		// Track written during a step does not anchor; the falling step flag does.
		directed_rows.push_back(predicted(ram_write(STATUS_ADDR_RESET, 8'h40)));
		directed_rows.push_back(predicted(ram_write(TRACK_ADDR_RESET, 8'd100)));
		directed_rows.push_back(predicted(ram_write(STATUS_ADDR_RESET, 8'h00)));
		// Top track anchors at the upper limit, and further steps up hold there.
		directed_rows.push_back(predicted(ram_write(TRACK_ADDR_RESET, 8'd127)));
		directed_rows.push_back(predicted(ram_write(STATUS_ADDR_RESET, 8'hFF)));
		directed_rows.push_back(predicted(ram_write(STATUS_ADDR_RESET, 8'hBF)));
		directed_rows.push_back(predicted(port_b(13'h0000, 1'b1, 2'd1, 2'd0)));
		// Track one anchors at the lower limit, and steps down hold there.
		directed_rows.push_back(predicted(ram_write(TRACK_ADDR_RESET, 8'd1)));
		directed_rows.push_back(predicted(port_b(13'h0000, 1'b1, 2'd0, 2'd0)));
		directed_rows.push_back(predicted(port_b(13'h0000, 1'b1, 2'd2, 2'd0)));
		// Out-of-range track bytes never anchor, even on a falling step flag.
		directed_rows.push_back(predicted(ram_write(TRACK_ADDR_RESET, 8'd0)));
		directed_rows.push_back(predicted(ram_write(TRACK_ADDR_RESET, 8'd255)));
		directed_rows.push_back(predicted(ram_write(STATUS_ADDR_RESET, 8'h40)));
		directed_rows.push_back(predicted(ram_write(STATUS_ADDR_RESET, 8'h00)));

		foreach (directed_rows[i])
			send_snapshot(directed_rows[i]);
		drain_events();

		// All three variables at address zero: one write gives up to four events.
		write_watch_addrs(13'h0000, 13'h0000, 13'h0000);
		random_run(RANDOM_ITEMS);
		drain_events();

		sender_gap_pct = 61;
		receiver_stall_pct = 36;
		write_watch_addrs(13'h1FFF, 13'h1FFE, 13'h1FFF);
		random_run(RANDOM_ITEMS);
		drain_events();

		sender_gap_pct = 0;
		receiver_stall_pct = 0;
		write_watch_addrs(PROTECT_ADDR_RESET, STATUS_ADDR_RESET, TRACK_ADDR_RESET);
		random_run(RANDOM_ITEMS);
		drain_events();

		if (mismatches == 0 && expected_events.size() == 0) begin
			$display("** drive_bus_write_event_decoder: PASSED **");
		end else begin
			$display("** drive_bus_write_event_decoder: FAILED **");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/dbwe_pkg.sv
design/dbwe_front.sv
design/dbwe_queue.sv
design/dbwe_back.sv
design/drive_bus_write_event_decoder.sv
design/dbwe_checker.sv
tb/drive_bus_write_event_decoder_tb.sv
